@@ rtl/maze_union_find_carver_unit_assert.svh @@
// Assertion macros used by the checker file of the maze carver.
`ifndef MAZE_UNION_FIND_CARVER_UNIT_ASSERT_SVH
`define MAZE_UNION_FIND_CARVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MUFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mufc check failed");

// Next-cycle implication, disabled while reset is low.
`define MUFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mufc check failed");

`endif

@@ rtl/mufc_pkg.sv @@
package mufc_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int CCNT_W      = $clog2(MAX_COLUMNS);
    localparam int MAX_DIM     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int SIZE_W      = $clog2(MAX_DIM + 1);

    localparam int ACTION_W    = 2;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 5;
    localparam int LABEL_W     = 10;
    localparam int WALL_W      = 4;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_JOIN  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET   = 6'd32;

    localparam logic [WALL_W-1:0] WALL_TOP    = 4'b0001;
    localparam logic [WALL_W-1:0] WALL_BOTTOM = 4'b0010;
    localparam logic [WALL_W-1:0] WALL_LEFT   = 4'b0100;
    localparam logic [WALL_W-1:0] WALL_RIGHT  = 4'b1000;
    localparam logic [WALL_W-1:0] WALL_CLOSED = 4'b1111;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [LABEL_W-1:0] t_label;
    typedef logic [WALL_W-1:0]  t_wall;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [CFG_W-1:0]   t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_JOIN_A,
        ST_JOIN_B,
        ST_JOIN_C,
        ST_JOIN_D,
        ST_WALL_B,
        ST_RELABEL,
        ST_READ,
        ST_READ_W,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic                direction;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [ACTION_W-1:0] action;
    } t_item;

    typedef struct packed {
        t_label set_label;
        t_wall  walls;
        logic   invalid;
        logic   merged;
    } t_result;

    typedef struct packed {
        logic   lbl_we;
        t_addr  lbl_waddr;
        t_label lbl_wdata;
        t_addr  lbl_raddr;
        logic   wall_we;
        t_addr  wall_waddr;
        t_wall  wall_wdata;
        t_addr  wall_raddr;
    } t_mem_req;

    function automatic t_size clamp_size(input t_cfg v, input int maxv);
        int val;
        val = int'(v);
        if (val == 0) begin
            val = 1;
        end else if (val > maxv) begin
            val = maxv;
        end
        return SIZE_W'(val);
    endfunction

    function automatic t_addr cell_addr(input int r, input int c);
        return ADDR_W'(r * MAX_COLUMNS + c);
    endfunction

endpackage

@@ rtl/mufc_ram.sv @@
module mufc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/mufc_seq.sv @@
module mufc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mufc_pkg::t_item    i_item,
    input  mufc_pkg::t_size    i_cols,
    input  mufc_pkg::t_size    i_rows,
    input  mufc_pkg::t_label   i_lbl_rdata,
    input  mufc_pkg::t_wall    i_wall_rdata,
    input  logic               i_res_free,
    output logic               o_idle,
    output mufc_pkg::t_mem_req o_mem,
    output logic               o_res_valid,
    output mufc_pkg::t_result  o_res
);

    mufc_pkg::t_state r_state;
    mufc_pkg::t_state n_state;

    logic                         r_boot;
    logic                         r_merged;
    logic [mufc_pkg::IDX_W-1:0]   r_idx;
    logic [mufc_pkg::CCNT_W-1:0]  r_clr_col;
    mufc_pkg::t_label             r_clr_base;
    mufc_pkg::t_size              r_clr_cols;

    mufc_pkg::t_item   r_item;
    logic              r_inside;
    logic              r_nbad;
    mufc_pkg::t_addr   r_here;
    mufc_pkg::t_addr   r_there;
    mufc_pkg::t_label  r_a;
    mufc_pkg::t_label  r_b;
    mufc_pkg::t_wall   r_wa;
    mufc_pkg::t_wall   r_wb;
    mufc_pkg::t_label  r_lo;
    mufc_pkg::t_label  r_hi;
    mufc_pkg::t_result r_res;

    logic                       s_inside;
    logic                       s_nbad;
    int                         s_nrow;
    int                         s_ncol;
    logic                       clr_last;
    logic                       sweep_end;
    logic [mufc_pkg::IDX_W-1:0] idx_prev;

    always_comb begin
        s_inside = (int'(i_item.row) < int'(i_rows)) && (int'(i_item.col) < int'(i_cols));
        s_nrow   = int'(i_item.row) + int'(i_item.direction);
        s_ncol   = int'(i_item.col) + (i_item.direction ? 0 : 1);
        s_nbad   = (i_item.action == mufc_pkg::ACT_JOIN) && s_inside &&
                   ((s_nrow >= int'(i_rows)) || (s_ncol >= int'(i_cols)));
    end

    assign clr_last  = (r_idx == mufc_pkg::IDX_W'(mufc_pkg::CELL_COUNT - 1));
    assign sweep_end = (r_idx == mufc_pkg::IDX_W'(mufc_pkg::CELL_COUNT));
    assign idx_prev  = r_idx - mufc_pkg::IDX_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mufc_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_item.action == mufc_pkg::ACT_CLEAR) begin
                        n_state = mufc_pkg::ST_CLEAR;
                    end else if ((i_item.action == mufc_pkg::ACT_JOIN) && s_inside &&
                                 !s_nbad) begin
                        n_state = mufc_pkg::ST_JOIN_A;
                    end else begin
                        n_state = mufc_pkg::ST_READ;
                    end
                end
            end
            mufc_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = r_boot ? mufc_pkg::ST_IDLE : mufc_pkg::ST_READ;
                end
            end
            mufc_pkg::ST_JOIN_A: n_state = mufc_pkg::ST_JOIN_B;
            mufc_pkg::ST_JOIN_B: n_state = mufc_pkg::ST_JOIN_C;
            mufc_pkg::ST_JOIN_C: n_state = mufc_pkg::ST_JOIN_D;
            mufc_pkg::ST_JOIN_D: begin
                n_state = (r_a != r_b) ? mufc_pkg::ST_WALL_B : mufc_pkg::ST_READ;
            end
            mufc_pkg::ST_WALL_B: n_state = mufc_pkg::ST_RELABEL;
            mufc_pkg::ST_RELABEL: begin
                if (sweep_end) begin
                    n_state = mufc_pkg::ST_READ;
                end
            end
            mufc_pkg::ST_READ:   n_state = mufc_pkg::ST_READ_W;
            mufc_pkg::ST_READ_W: n_state = mufc_pkg::ST_RESP;
            mufc_pkg::ST_RESP: begin
                if (i_res_free) begin
                    n_state = mufc_pkg::ST_IDLE;
                end
            end
            default: n_state = mufc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_mem            = '0;
        o_mem.lbl_raddr  = r_here;
        o_mem.wall_raddr = r_here;
        o_idle           = 1'b0;
        o_res_valid      = 1'b0;
        unique case (r_state)
            mufc_pkg::ST_IDLE: o_idle = 1'b1;
            mufc_pkg::ST_CLEAR: begin
                o_mem.lbl_we     = 1'b1;
                o_mem.lbl_waddr  = r_idx[mufc_pkg::ADDR_W-1:0];
                o_mem.lbl_wdata  = r_clr_base + mufc_pkg::LABEL_W'(r_clr_col);
                o_mem.wall_we    = 1'b1;
                o_mem.wall_waddr = r_idx[mufc_pkg::ADDR_W-1:0];
                o_mem.wall_wdata = mufc_pkg::WALL_CLOSED;
            end
            mufc_pkg::ST_JOIN_B: begin
                o_mem.lbl_raddr  = r_there;
                o_mem.wall_raddr = r_there;
            end
            mufc_pkg::ST_JOIN_D: begin
                o_mem.wall_we    = (r_a != r_b);
                o_mem.wall_waddr = r_here;
                o_mem.wall_wdata = r_wa & ~(r_item.direction ? mufc_pkg::WALL_BOTTOM
                                                              : mufc_pkg::WALL_RIGHT);
            end
            mufc_pkg::ST_WALL_B: begin
                o_mem.wall_we    = 1'b1;
                o_mem.wall_waddr = r_there;
                o_mem.wall_wdata = r_wb & ~(r_item.direction ? mufc_pkg::WALL_TOP
                                                              : mufc_pkg::WALL_LEFT);
            end
            mufc_pkg::ST_RELABEL: begin
                o_mem.lbl_raddr = r_idx[mufc_pkg::ADDR_W-1:0];
                o_mem.lbl_we    = (r_idx != '0) && (i_lbl_rdata == r_hi);
                o_mem.lbl_waddr = idx_prev[mufc_pkg::ADDR_W-1:0];
                o_mem.lbl_wdata = r_lo;
            end
            mufc_pkg::ST_RESP: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mufc_pkg::ST_CLEAR;
            r_boot     <= 1'b1;
            r_merged   <= 1'b0;
            r_idx      <= '0;
            r_clr_col  <= '0;
            r_clr_base <= '0;
            r_clr_cols <= mufc_pkg::clamp_size(mufc_pkg::CFG_RESET, mufc_pkg::MAX_COLUMNS);
        end else begin
            r_state <= n_state;
            unique case (r_state)
                mufc_pkg::ST_IDLE: begin
                    if (i_start) begin
                        r_merged   <= 1'b0;
                        r_idx      <= '0;
                        r_clr_col  <= '0;
                        r_clr_base <= '0;
                        r_clr_cols <= i_cols;
                    end
                end
                mufc_pkg::ST_CLEAR: begin
                    r_idx <= r_idx + mufc_pkg::IDX_W'(1);
                    if (r_clr_col == mufc_pkg::CCNT_W'(mufc_pkg::MAX_COLUMNS - 1)) begin
                        r_clr_col  <= '0;
                        r_clr_base <= r_clr_base + mufc_pkg::LABEL_W'(r_clr_cols);
                    end else begin
                        r_clr_col <= r_clr_col + mufc_pkg::CCNT_W'(1);
                    end
                    if (clr_last) begin
                        r_boot <= 1'b0;
                    end
                end
                mufc_pkg::ST_JOIN_D: begin
                    if (r_a != r_b) begin
                        r_merged <= 1'b1;
                    end
                end
                mufc_pkg::ST_WALL_B:  r_idx <= '0;
                mufc_pkg::ST_RELABEL: r_idx <= r_idx + mufc_pkg::IDX_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mufc_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_item   <= i_item;
                    r_inside <= s_inside;
                    r_nbad   <= s_nbad;
                    r_here   <= s_inside ? mufc_pkg::cell_addr(int'(i_item.row),
                                                               int'(i_item.col)) : '0;
                    r_there  <= mufc_pkg::cell_addr(s_nrow, s_ncol);
                end
            end
            mufc_pkg::ST_JOIN_B: begin
                r_a  <= i_lbl_rdata;
                r_wa <= i_wall_rdata;
            end
            mufc_pkg::ST_JOIN_C: begin
                r_b  <= i_lbl_rdata;
                r_wb <= i_wall_rdata;
            end
            mufc_pkg::ST_JOIN_D: begin
                r_lo <= (r_a < r_b) ? r_a : r_b;
                r_hi <= (r_a < r_b) ? r_b : r_a;
            end
            mufc_pkg::ST_READ_W: begin
                r_res.merged    <= r_merged;
                r_res.invalid   <= !r_inside || r_nbad;
                r_res.walls     <= r_inside ? i_wall_rdata : '0;
                r_res.set_label <= r_inside ? i_lbl_rdata : '0;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/maze_union_find_carver_unit.sv @@
// Channel    Direction  Handshake          Payload
// s_axis     in         tvalid / tready    tdata: action, row, col, direction
// m_axis     out        tvalid / tready    tdata: merged, invalid, walls, set_label
// cfg        in         valid / ready      index 0 columns, 1 rows; 6-bit data
//
// A merging join or a clear sweeps all 1024 cells of the label memory, one per
// cycle; the single read and write port of that memory sets this rate. After
// reset the block runs the same sweep to initialize both memories, with s_axis
// tready low; configuration writes are accepted at all times. One item is in
// work at a time, and a finished result waits in the output register while the
// next item is accepted.
module maze_union_find_carver_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Bits from low: action[1:0], row[6:2], col[11:7], direction[12], zero[15:13].
    input  logic [mufc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Bits from low: merged[0], invalid[1], walls[5:2], set_label[15:6].
    output logic [mufc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mufc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mufc_pkg::CFG_W-1:0]          i_cfg_data
);

    mufc_pkg::t_cfg     r_cols;
    mufc_pkg::t_cfg     r_rows;
    logic               r_out_valid;
    mufc_pkg::t_result  r_out;

    mufc_pkg::t_item    item;
    mufc_pkg::t_size    cols_c;
    mufc_pkg::t_size    rows_c;
    mufc_pkg::t_mem_req mem;
    mufc_pkg::t_label   lbl_rdata;
    mufc_pkg::t_wall    wall_rdata;
    mufc_pkg::t_result  res;
    logic               res_valid;
    logic               res_free;
    logic               idle;
    logic               start;

    assign item.action    = i_s_axis_tdata[1:0];
    assign item.row       = i_s_axis_tdata[6:2];
    assign item.col       = i_s_axis_tdata[11:7];
    assign item.direction = i_s_axis_tdata[12];

    assign cols_c = mufc_pkg::clamp_size(r_cols, mufc_pkg::MAX_COLUMNS);
    assign rows_c = mufc_pkg::clamp_size(r_rows, mufc_pkg::MAX_ROWS);

    assign o_s_axis_tready = idle;
    assign start           = i_s_axis_tvalid && idle;
    assign res_free        = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= mufc_pkg::CFG_RESET;
            r_rows <= mufc_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mufc_pkg::CFG_COLUMNS: r_cols <= i_cfg_data;
                mufc_pkg::CFG_ROWS:    r_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    mufc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (item),
        .i_cols       (cols_c),
        .i_rows       (rows_c),
        .i_lbl_rdata  (lbl_rdata),
        .i_wall_rdata (wall_rdata),
        .i_res_free   (res_free),
        .o_idle       (idle),
        .o_mem        (mem),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    mufc_ram #(
        .WIDTH (mufc_pkg::LABEL_W),
        .DEPTH (mufc_pkg::CELL_COUNT)
    ) u_lbl_ram (
        .i_clk   (i_clk),
        .i_we    (mem.lbl_we),
        .i_waddr (mem.lbl_waddr),
        .i_wdata (mem.lbl_wdata),
        .i_raddr (mem.lbl_raddr),
        .o_rdata (lbl_rdata)
    );

    mufc_ram #(
        .WIDTH (mufc_pkg::WALL_W),
        .DEPTH (mufc_pkg::CELL_COUNT)
    ) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (mem.wall_we),
        .i_waddr (mem.wall_waddr),
        .i_wdata (mem.wall_wdata),
        .i_raddr (mem.wall_raddr),
        .o_rdata (wall_rdata)
    );

endmodule

@@ rtl/mufc_chk.sv @@
`include "maze_union_find_carver_unit_assert.svh"

module mufc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             i_s_axis_tready,
    input logic                             i_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [mufc_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata
);

    // A result that is not taken stays in place.
    `MUFC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata))

    // Every item keeps the block busy after its accept, so an accept is never followed by another.
    `MUFC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && i_s_axis_tready, !i_s_axis_tready)

    // A flagged item never merges two sets.
    `MUFC_ASSERT_IMP(a_invalid_no_merge, i_clk, i_rst_n, i_m_axis_tvalid, !(i_m_axis_tdata[0] && i_m_axis_tdata[1]))

    // A merge always opens one wall of the addressed cell.
    `MUFC_ASSERT_IMP(a_merge_opens_wall, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tdata[0], i_m_axis_tdata[5:2] != mufc_pkg::WALL_CLOSED)

endmodule

bind maze_union_find_carver_unit mufc_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
